FILE: design/gost_pkg.sv
// Package for the GOST R 34.11-94 hash block: queue sizes, request type, key constant, S-boxes,
// round function and the A, P and psi transforms. No dependencies.
package gost_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_req;

    localparam logic [255:0] KEY_CONST = {
        8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF,
        8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00,
        8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
        8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00
    };

    function automatic logic [3:0] sbox(input logic [2:0] n, input logic [3:0] x);
        logic [63:0] row;
        case (n)
            3'd0: row = 64'h3_5_F_7_C_1_B_6_E_0_8_D_2_9_A_4;
            3'd1: row = 64'h9_5_7_0_1_8_3_2_A_F_D_6_C_4_B_E;
            3'd2: row = 64'hB_9_0_6_7_C_F_E_2_4_3_A_D_1_8_5;
            3'd3: row = 64'h3_5_2_B_C_6_4_E_F_9_8_0_1_A_D_7;
            3'd4: row = 64'h2_B_3_0_E_9_A_4_8_D_F_5_1_7_C_6;
            3'd5: row = 64'hE_F_C_9_5_8_6_3_D_1_2_7_0_A_B_4;
            3'd6: row = 64'hC_2_8_6_7_E_A_0_9_5_F_3_1_4_B_D;
            default: row = 64'hC_8_B_6_E_3_2_9_4_A_7_5_0_D_F_1;
        endcase
        return row[x*4 +: 4];
    endfunction

    function automatic logic [31:0] round_fn(input logic [31:0] x, input logic [31:0] k);
        logic [31:0] s;
        logic [31:0] r;
        s = x + k;
        for (int i = 0; i < 8; i++) begin
            r[i*4 +: 4] = sbox(3'(i), s[i*4 +: 4]);
        end
        return {r[20:0], r[31:21]};
    endfunction

    function automatic logic [255:0] a_tf(input logic [255:0] y);
        return {y[63:0] ^ y[127:64], y[255:64]};
    endfunction

    function automatic logic [255:0] p_tf(input logic [255:0] y);
        logic [255:0] r;
        for (int i = 0; i < 32; i++) begin
            r[i*8 +: 8] = y[(((i % 4) * 8) + (i / 4))*8 +: 8];
        end
        return r;
    endfunction

    function automatic logic [255:0] psi1(input logic [255:0] a);
        logic [15:0] f;
        f = a[15:0] ^ a[31:16] ^ a[47:32] ^ a[63:48] ^ a[207:192] ^ a[255:240];
        return {f, a[255:16]};
    endfunction

endpackage

FILE: design/gost_front.sv
// Front end: takes input requests, drops idle ones, queues the rest.
// Depends on gost_pkg.
module gost_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  gost_pkg::t_req  i_req,
    output logic            o_q_valid,
    input  logic            i_q_ready,
    output gost_pkg::t_req  o_q_req
);
    gost_pkg::t_req r_mem [gost_pkg::QDEPTH];
    logic [gost_pkg::QAW-1:0] r_wp, r_rp;
    logic [gost_pkg::QAW:0]   r_cnt;
    logic push, pop, useful;

    assign useful    = i_req.byte_present | i_req.end_of_message;
    assign o_ready   = (r_cnt != 3'(gost_pkg::QDEPTH));
    assign push      = i_valid & o_ready & useful;
    assign o_q_valid = (r_cnt != '0);
    assign pop       = o_q_valid & i_q_ready;
    assign o_q_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_req;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {2'b0, push} - {2'b0, pop};
        end
    end
endmodule

FILE: design/gost_back.sv
// Back end: block buffer, checksum, compression (four ciphers in parallel) and output.
// Depends on gost_pkg.
module gost_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_q_ready,
    input  gost_pkg::t_req  i_q_req,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [63:0]     o_hash_word,
    output logic [1:0]      o_word_index,
    output logic            o_last_word
);
    localparam logic [3:0] S_IDLE = 4'd0, S_KEY = 4'd1, S_ENC = 4'd2, S_PSI = 4'd3,
                           S_PAD = 4'd4, S_LEN = 4'd5, S_SUM = 4'd6, S_OUT = 4'd7,
                           S_CSUM = 4'd8;
    localparam logic [1:0] P_DATA = 2'd0, P_LEN = 2'd1, P_SUM = 2'd2;

    logic [3:0]   r_st;
    logic [1:0]   r_phase;
    logic         r_fin;
    logic [255:0] r_h, r_sum, r_buf, r_m, r_u, r_v, r_s;
    logic [255:0] r_key [4];
    logic [63:0]  r_ab [4];
    logic [4:0]   r_pos, r_cnt;
    logic [63:0]  r_len;
    logic [1:0]   r_ks;
    logic [6:0]   r_psi;
    logic [2:0]   key_sel;
    logic [1:0]   r_oi;
    logic [256:0] sum_w;
    logic [255:0] w, u_n, v_n, s_n;

    assign o_q_ready   = (r_st == S_IDLE);
    assign o_valid     = (r_st == S_OUT);
    assign o_hash_word = r_h[r_oi*64 +: 64];
    assign o_word_index = r_oi;
    assign o_last_word = (r_oi == 2'd3);
    assign sum_w = {1'b0, r_sum} + {1'b0, r_buf};
    assign u_n = gost_pkg::a_tf(r_u) ^ ((r_ks == 2'd2) ? gost_pkg::KEY_CONST : '0);
    assign v_n = gost_pkg::a_tf(gost_pkg::a_tf(r_v));
    assign w   = (r_ks == 2'd0) ? (r_u ^ r_v) : (u_n ^ v_n);
    // rounds 24..31 take the subkeys in reverse
    assign key_sel = (r_cnt < 5'd24) ? r_cnt[2:0] : ~r_cnt[2:0];
    // psi schedule: 12 shifts, xor m, 1, xor h, 61
    always_comb begin
        s_n = gost_pkg::psi1(r_s);
        if (r_psi == 7'd13) s_n = gost_pkg::psi1(r_s ^ r_m);
        if (r_psi == 7'd14) s_n = gost_pkg::psi1(r_s ^ r_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_pos <= '0; r_len <= '0; r_sum <= '0; r_h <= '0;
            r_fin <= 1'b0; r_oi <= '0; r_phase <= P_DATA;
        end else begin
            case (r_st)
                S_IDLE: if (i_q_valid) begin
                    r_fin <= i_q_req.end_of_message;
                    if (i_q_req.byte_present) begin
                        r_buf[r_pos*8 +: 8] <= i_q_req.data_byte;
                        r_pos <= r_pos + 1'b1;
                        r_len <= r_len + 64'd8;
                        if (r_pos == 5'd31) r_st <= S_CSUM;
                        else if (i_q_req.end_of_message) begin
                            r_st <= S_PAD; r_cnt <= r_pos + 1'b1;
                        end
                    end else if (i_q_req.end_of_message) begin
                        if (r_pos != '0) begin
                            r_st <= S_PAD; r_cnt <= r_pos;
                        end else r_st <= S_LEN;
                    end
                end
                S_PAD: begin
                    r_buf[r_cnt*8 +: 8] <= 8'h00;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd31) r_st <= S_CSUM;
                end
                S_CSUM: begin
                    r_sum <= sum_w[255:0];
                    r_m <= r_buf; r_u <= r_h; r_v <= r_buf; r_ks <= '0;
                    r_phase <= P_DATA; r_pos <= '0; r_st <= S_KEY;
                end
                S_LEN: begin
                    r_m <= {192'd0, r_len}; r_u <= r_h; r_v <= {192'd0, r_len};
                    r_ks <= '0; r_phase <= P_LEN; r_st <= S_KEY;
                end
                S_SUM: begin
                    r_m <= r_sum; r_u <= r_h; r_v <= r_sum;
                    r_ks <= '0; r_phase <= P_SUM; r_st <= S_KEY;
                end
                S_KEY: begin
                    r_key[r_ks] <= gost_pkg::p_tf(w);
                    if (r_ks != 2'd0) begin
                        r_u <= u_n; r_v <= v_n;
                    end
                    r_ks <= r_ks + 1'b1;
                    if (r_ks == 2'd3) begin
                        for (int i = 0; i < 4; i++) r_ab[i] <= r_h[i*64 +: 64];
                        r_cnt <= '0; r_st <= S_ENC;
                    end
                end
                S_ENC: begin
                    for (int i = 0; i < 4; i++) begin
                        r_ab[i] <= {r_ab[i][31:0],
                            gost_pkg::round_fn(r_ab[i][31:0], r_key[i][key_sel*32 +: 32])
                            ^ r_ab[i][63:32]};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd31) r_st <= S_PSI;
                    r_psi <= '0;
                end
                S_PSI: begin
                    // first cycle loads swapped cipher outputs
                    if (r_psi == 7'd0) begin
                        for (int i = 0; i < 4; i++)
                            r_s[i*64 +: 64] <= {r_ab[i][31:0], r_ab[i][63:32]};
                        r_psi <= 7'd1;
                    end else begin
                        r_s <= s_n;
                        r_psi <= r_psi + 1'b1;
                        if (r_psi == 7'd74) begin
                            r_h <= s_n;
                            if (r_phase == P_SUM) begin
                                r_st <= S_OUT; r_oi <= '0;
                            end else if (r_phase == P_LEN) r_st <= S_SUM;
                            else if (r_fin) r_st <= S_LEN;
                            else r_st <= S_IDLE;
                        end
                    end
                end
                S_OUT: if (i_ready) begin
                    r_oi <= r_oi + 1'b1;
                    if (r_oi == 2'd3) begin
                        r_st <= S_IDLE; r_h <= '0; r_sum <= '0; r_len <= '0;
                        r_pos <= '0; r_fin <= 1'b0;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: design/gost_34_11_94_hash_top.sv
// Top level of the GOST R 34.11-94 hash: front queue feeding the compression back end.
// Depends on gost_pkg, gost_front, gost_back.
//  channel | handshake          | payload
//  in      | i_valid / o_ready  | i_data_byte, i_byte_present, i_end_of_message
//  out     | o_valid / i_ready  | o_hash_word, o_word_index, o_last_word
// A byte that does not fill a block is stored and counted; the byte that fills one starts
// the checksum add, key generation, 32 rounds in four parallel lanes, a load and 74 psi steps.
// End of message pads one byte a cycle, then runs two more compressions.
// Reset is synchronous, active low. The 4-deep queue keeps input flowing while the back end is busy, until full.
module gost_34_11_94_hash_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_hash_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);
    gost_pkg::t_req req, q_req;
    logic q_valid, q_ready;

    assign req = '{data_byte: i_data_byte, byte_present: i_byte_present,
                   end_of_message: i_end_of_message};

    gost_front u_front (.i_clk, .i_rst_n, .i_valid, .o_ready, .i_req(req),
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_req(q_req));
    gost_back u_back (.i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_ready(q_ready),
        .i_q_req(q_req), .o_valid, .i_ready, .o_hash_word, .o_word_index, .o_last_word);
endmodule

FILE: design/gost_checker.sv
// Port-level checker for the hash top level, with its bind.
// Depends on gost_34_11_94_hash_top ports only.
module gost_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_word_index,
    input logic        o_last_word,
    input logic [63:0] o_hash_word
);
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == 2'd3))) else $error("last flag");
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_word |=> o_valid && o_word_index == $past(o_word_index) + 2'd1)
        else $error("word order");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hash_word)) else $error("hold");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid) else $error("reset");
endmodule

bind gost_34_11_94_hash_top gost_checker u_chk (.i_clk, .i_rst_n, .o_valid, .i_ready,
    .o_word_index, .o_last_word, .o_hash_word);
